[src/clex_pkg.sv]
// Shared types, token codes and character helpers for the C subset lexer.
// No dependencies; used by every module of the block.
package clex_pkg;

  localparam int unsigned POS_WIDTH_DEF  = 16;
  localparam int unsigned LINE_WIDTH_DEF = 16;
  localparam int unsigned FIFO_DEPTH     = 4;

  localparam logic [5:0] TK_ID        = 6'd0;
  localparam logic [5:0] TK_CT_INT    = 6'd12;
  localparam logic [5:0] TK_CT_REAL   = 6'd13;
  localparam logic [5:0] TK_CT_CHAR   = 6'd14;
  localparam logic [5:0] TK_CT_STRING = 6'd15;
  localparam logic [5:0] TK_COMMA     = 6'd16;
  localparam logic [5:0] TK_SEMICOLON = 6'd17;
  localparam logic [5:0] TK_LPAR      = 6'd18;
  localparam logic [5:0] TK_RPAR      = 6'd19;
  localparam logic [5:0] TK_LBRACKET  = 6'd20;
  localparam logic [5:0] TK_RBRACKET  = 6'd21;
  localparam logic [5:0] TK_LACC      = 6'd22;
  localparam logic [5:0] TK_RACC      = 6'd23;
  localparam logic [5:0] TK_ADD       = 6'd24;
  localparam logic [5:0] TK_MUL       = 6'd25;
  localparam logic [5:0] TK_SUB       = 6'd26;
  localparam logic [5:0] TK_DIV       = 6'd27;
  localparam logic [5:0] TK_DOT       = 6'd28;
  localparam logic [5:0] TK_AND       = 6'd29;
  localparam logic [5:0] TK_OR        = 6'd30;
  localparam logic [5:0] TK_NOT       = 6'd31;
  localparam logic [5:0] TK_ASSIGN    = 6'd32;
  localparam logic [5:0] TK_EQUAL     = 6'd33;
  localparam logic [5:0] TK_NOTEQ     = 6'd34;
  localparam logic [5:0] TK_LESS      = 6'd35;
  localparam logic [5:0] TK_LESSEQ    = 6'd36;
  localparam logic [5:0] TK_GREATER   = 6'd37;
  localparam logic [5:0] TK_GREATEREQ = 6'd38;
  localparam logic [5:0] TK_END       = 6'd39;
  localparam logic [5:0] TK_ERR       = 6'd40;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  localparam logic [47:0] KW_WORD [11] = '{
    48'("break"), 48'("char"), 48'("double"), 48'("else"), 48'("for"), 48'("if"),
    48'("int"), 48'("return"), 48'("struct"), 48'("void"), 48'("while")
  };

  typedef struct packed {
    logic [5:0]  code;
    logic [15:0] line;
    logic [15:0] start;
    logic [15:0] len;
    logic        last;
  } token_t;

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_alnum(input logic [7:0] b);
    return is_alpha(b) || is_digit(b);
  endfunction

  function automatic logic is_esc(input logic [7:0] b);
    return b == "a" || b == "b" || b == "f" || b == "n" || b == "r" || b == "t" ||
           b == "v" || b == "'" || b == "?" || b == "\"" || b == "\\" || b == "0";
  endfunction

  function automatic logic [5:0] single_code(input logic [7:0] b);
    logic [5:0] c;
    case (b)
      ",":     c = TK_COMMA;
      ";":     c = TK_SEMICOLON;
      "(":     c = TK_LPAR;
      ")":     c = TK_RPAR;
      "[":     c = TK_LBRACKET;
      "]":     c = TK_RBRACKET;
      "{":     c = TK_LACC;
      "}":     c = TK_RACC;
      "+":     c = TK_ADD;
      "*":     c = TK_MUL;
      "-":     c = TK_SUB;
      ".":     c = TK_DOT;
      default: c = TK_ID;
    endcase
    return c;
  endfunction

  function automatic logic [5:0] word_code(input logic [47:0] w);
    logic [5:0] c;
    c = TK_ID;
    for (int k = 0; k < 11; k++) begin
      if (KW_WORD[k] == w) c = 6'(k + 1);
    end
    return c;
  endfunction

endpackage

[src/clex_scan.sv]
// Lexer automaton: scan state, positions and the one-byte step with rescan.
// Depends on clex_pkg.
module clex_scan import clex_pkg::*; #(
  parameter int unsigned POS_WIDTH  = POS_WIDTH_DEF,
  parameter int unsigned LINE_WIDTH = LINE_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  output logic [1:0] push_n_o,
  output token_t     ent0_o,
  output token_t     ent1_o
);

  typedef enum logic [27:0] {
    S_START     = 28'd1 << 0,  S_IDENT    = 28'd1 << 1,  S_AMP     = 28'd1 << 2,
    S_BAR       = 28'd1 << 3,  S_BANG     = 28'd1 << 4,  S_EQ      = 28'd1 << 5,
    S_LT        = 28'd1 << 6,  S_GT       = 28'd1 << 7,  S_SLASH   = 28'd1 << 8,
    S_LINECMT   = 28'd1 << 9,  S_BLOCK    = 28'd1 << 10, S_BLOCKSTAR = 28'd1 << 11,
    S_DEC       = 28'd1 << 12, S_ZERO     = 28'd1 << 13, S_OCT     = 28'd1 << 14,
    S_HEX0      = 28'd1 << 15, S_HEX      = 28'd1 << 16, S_OCTBAD  = 28'd1 << 17,
    S_FRAC0     = 28'd1 << 18, S_FRAC     = 28'd1 << 19, S_EXPSIGN = 28'd1 << 20,
    S_EXP0      = 28'd1 << 21, S_EXP      = 28'd1 << 22, S_CHR0    = 28'd1 << 23,
    S_CHRESC    = 28'd1 << 24, S_CHREND   = 28'd1 << 25, S_STR     = 28'd1 << 26,
    S_STRESC    = 28'd1 << 27
  } scan_state_e;

  scan_state_e           state_q, state_d;
  logic [LINE_WIDTH-1:0] line_q, line_d;
  logic [POS_WIDTH-1:0]  pos_q, tstart_q, tstart_d, nxt;
  logic [47:0]           word_q, word_d;
  logic                  halted_q, halt, line_inc, rescan, step;
  logic                  e1, e2;
  logic [5:0]            e1_code, e2_code;
  logic [POS_WIDTH-1:0]  e1_start, e1_end, e2_end, len1, len2;
  logic [7:0]            b;
  logic [5:0]            sc;
  token_t                r1, r2;

  assign b    = byte_i;
  assign sc   = single_code(b);
  assign nxt  = (pos_q == '1) ? pos_q : pos_q + 1'b1;
  assign step = fire_i && !halted_q;

  always_comb begin
    state_d  = state_q;
    tstart_d = tstart_q;
    word_d   = word_q;
    halt     = 1'b0;
    line_inc = 1'b0;
    rescan   = 1'b0;
    e1       = 1'b0;
    e1_code  = TK_ID;
    e1_start = tstart_q;
    e1_end   = pos_q;
    e2       = 1'b0;
    e2_code  = TK_ID;
    e2_end   = pos_q;
    unique case (state_q)
      S_START: rescan = 1'b1;
      S_IDENT: begin
        if (is_alnum(b) || b == "_") begin
          word_d = (word_q[47:40] != 8'd0) ? '1 : {word_q[39:0], b};
        end else begin
          e1 = 1'b1; e1_code = word_code(word_q); rescan = 1'b1;
        end
      end
      S_AMP, S_BAR: begin
        if (b == ((state_q == S_AMP) ? "&" : "|")) begin
          e1 = 1'b1; e1_code = (state_q == S_AMP) ? TK_AND : TK_OR; e1_end = nxt;
          state_d = S_START;
        end else begin
          e1 = 1'b1; e1_code = TK_ERR;
        end
      end
      S_BANG, S_EQ, S_LT, S_GT: begin
        e1 = 1'b1;
        if (b != "=") begin
          rescan = 1'b1;
          e1_code = (state_q == S_BANG) ? TK_NOT : (state_q == S_EQ) ? TK_ASSIGN :
                    (state_q == S_LT) ? TK_LESS : TK_GREATER;
        end else begin
          e1_end = nxt; state_d = S_START;
          e1_code = (state_q == S_BANG) ? TK_NOTEQ : (state_q == S_EQ) ? TK_EQUAL :
                    (state_q == S_LT) ? TK_LESSEQ : TK_GREATEREQ;
        end
      end
      S_SLASH: begin
        if (b == "/") state_d = S_LINECMT;
        else if (b == "*") state_d = S_BLOCK;
        else begin
          e1 = 1'b1; e1_code = TK_DIV; rescan = 1'b1;
        end
      end
      S_LINECMT: begin
        if (b == CH_LF || b == CH_CR || b == CH_NUL) rescan = 1'b1;
      end
      S_BLOCK, S_BLOCKSTAR: begin
        if (b == CH_NUL) begin
          e1 = 1'b1; e1_code = TK_ERR;
        end else if (b == "*") state_d = S_BLOCKSTAR;
        else if (b == "/" && state_q == S_BLOCKSTAR) state_d = S_START;
        else begin
          state_d = S_BLOCK; line_inc = (b == CH_LF);
        end
      end
      S_DEC, S_ZERO, S_OCT: begin
        if (is_digit(b) && state_q == S_DEC) state_d = S_DEC;
        else if (b >= "0" && b <= "7") state_d = S_OCT;
        else if (b == "8" || b == "9") state_d = S_OCTBAD;
        else if (b == "x" && state_q == S_ZERO) state_d = S_HEX0;
        else if (b == ".") state_d = S_FRAC0;
        else if (b == "e" || b == "E") state_d = S_EXPSIGN;
        else begin
          e1 = 1'b1; e1_code = TK_CT_INT; rescan = 1'b1;
        end
      end
      S_HEX0: begin
        if (is_alnum(b)) state_d = S_HEX;
        else begin
          e1 = 1'b1; e1_code = TK_ERR;
        end
      end
      S_HEX: begin
        if (!is_alnum(b)) begin
          e1 = 1'b1; e1_code = TK_CT_INT; rescan = 1'b1;
        end
      end
      S_OCTBAD: begin
        if (is_digit(b)) state_d = S_OCTBAD;
        else if (b == ".") state_d = S_FRAC0;
        else if (b == "e" || b == "E") state_d = S_EXPSIGN;
        else begin
          e1 = 1'b1; e1_code = TK_ERR;
        end
      end
      S_FRAC0, S_EXP0: begin
        if (is_digit(b)) state_d = (state_q == S_FRAC0) ? S_FRAC : S_EXP;
        else begin
          e1 = 1'b1; e1_code = TK_ERR;
        end
      end
      S_FRAC: begin
        if (is_digit(b)) state_d = S_FRAC;
        else if (b == "e" || b == "E") state_d = S_EXPSIGN;
        else begin
          e1 = 1'b1; e1_code = TK_CT_REAL; rescan = 1'b1;
        end
      end
      S_EXPSIGN: begin
        if (b == "+" || b == "-") state_d = S_EXP0;
        else if (is_digit(b)) state_d = S_EXP;
        else begin
          e1 = 1'b1; e1_code = TK_ERR;
        end
      end
      S_EXP: begin
        if (!is_digit(b)) begin
          e1 = 1'b1; e1_code = TK_CT_REAL; rescan = 1'b1;
        end
      end
      S_CHR0: begin
        if (b == "\\") state_d = S_CHRESC;
        else if (b == "\"" || b == CH_NUL) begin
          e1 = 1'b1; e1_code = TK_ERR;
        end else state_d = S_CHREND;
      end
      S_CHRESC, S_STRESC: begin
        if (is_esc(b)) state_d = (state_q == S_CHRESC) ? S_CHREND : S_STR;
        else begin
          e1 = 1'b1; e1_code = TK_ERR;
        end
      end
      S_CHREND: begin
        e1 = 1'b1;
        if (b == "'") begin
          e1_code = TK_CT_CHAR; e1_end = nxt; state_d = S_START;
        end else e1_code = TK_ERR;
      end
      S_STR: begin
        if (b == "\\") state_d = S_STRESC;
        else if (b == "\"") begin
          e1 = 1'b1; e1_code = TK_CT_STRING; e1_end = nxt; state_d = S_START;
        end else if (b == CH_NUL) begin
          e1 = 1'b1; e1_code = TK_ERR;
        end
      end
      default: rescan = 1'b1;
    endcase

    if (e1 && e1_code == TK_ERR) begin
      e1_start = pos_q;
      e1_end   = nxt;
      tstart_d = pos_q;
      halt     = 1'b1;
      state_d  = S_START;
    end

    if (rescan) begin
      state_d  = S_START;
      tstart_d = pos_q;
      if (is_alpha(b) || b == "_") begin
        word_d = {40'd0, b}; state_d = S_IDENT;
      end else if (b == " " || b == CH_CR || b == CH_TAB) begin
        state_d = S_START;
      end else if (b == CH_LF) line_inc = 1'b1;
      else if (sc != TK_ID) begin
        e2 = 1'b1; e2_code = sc; e2_end = nxt;
      end else if (b == "&") state_d = S_AMP;
      else if (b == "|") state_d = S_BAR;
      else if (b == "!") state_d = S_BANG;
      else if (b == "=") state_d = S_EQ;
      else if (b == "<") state_d = S_LT;
      else if (b == ">") state_d = S_GT;
      else if (b == "/") state_d = S_SLASH;
      else if (b == "0") state_d = S_ZERO;
      else if (is_digit(b)) state_d = S_DEC;
      else if (b == "'") state_d = S_CHR0;
      else if (b == "\"") state_d = S_STR;
      else if (b == CH_NUL) begin
        e2 = 1'b1; e2_code = TK_END; halt = 1'b1;
      end else begin
        e2 = 1'b1; e2_code = TK_ERR; e2_end = nxt; halt = 1'b1;
      end
    end
  end

  assign line_d = (line_inc && line_q != '1) ? line_q + 1'b1 : line_q;
  assign len1   = e1_end - e1_start;
  assign len2   = e2_end - pos_q;

  always_comb begin
    r1       = '0;
    r1.code  = e1_code;
    r1.line  = 16'(line_q);
    r1.start = 16'(e1_start);
    r1.len   = 16'(len1);
    r1.last  = !e2;
    r2       = '0;
    r2.code  = e2_code;
    r2.line  = 16'(line_q);
    r2.start = 16'(pos_q);
    r2.len   = 16'(len2);
    r2.last  = 1'b1;
  end

  assign push_n_o = step ? (2'(e1) + 2'(e2)) : 2'd0;
  assign ent0_o   = e1 ? r1 : r2;
  assign ent1_o   = r2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_START;
      line_q   <= LINE_WIDTH'(1);
      pos_q    <= '0;
      tstart_q <= '0;
      word_q   <= '0;
      halted_q <= 1'b0;
    end else if (step) begin
      state_q  <= state_d;
      line_q   <= line_d;
      pos_q    <= nxt;
      tstart_q <= tstart_d;
      word_q   <= word_d;
      halted_q <= halt;
    end
  end

endmodule

[src/clex_fifo.sv]
// Small result queue that takes up to two tokens per cycle and gives one.
// Depends on clex_pkg.
module clex_fifo import clex_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_n_i,
  input  token_t     ent0_i,
  input  token_t     ent1_i,
  output logic       room_o,
  output logic       valid_o,
  input  logic       ready_i,
  output token_t     data_o
);

  localparam int unsigned AW = $clog2(FIFO_DEPTH);

  token_t        mem [FIFO_DEPTH];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;
  logic          pop;

  assign valid_o = cnt_q != '0;
  assign pop     = valid_o && ready_i;
  assign room_o  = cnt_q <= (AW+1)'(FIFO_DEPTH - 2);
  assign data_o  = mem[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) mem[wp_q] <= ent0_i;
    if (push_n_i == 2'd2) mem[wp_q + 1'b1] <= ent1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + AW'(push_n_i);
      rp_q  <= rp_q + AW'(pop);
      cnt_q <= cnt_q + (AW+1)'(push_n_i) - (AW+1)'(pop);
    end
  end

endmodule

[src/c_subset_lexer_dfa.sv]
// Top level of the C subset lexer: input register, automaton and result queue.
// Depends on clex_pkg, clex_scan and clex_fifo.
// The block takes one source byte per cycle and returns tokens with their line, start
// offset and length; one byte gives at most two tokens (one ended by lookahead, then one
// begun by the same byte). Each byte passes through an input register and one
// combinational automaton step into a four-entry result queue; a byte can be taken every
// cycle while the queue has two free entries. A zero byte yields END, or an error token
// where the token or comment under way cannot end there; a bad character or token yields
// an error token. After either, bytes are accepted and ignored until reset.
module c_subset_lexer_dfa import clex_pkg::*; #(
  parameter int unsigned POS_WIDTH  = POS_WIDTH_DEF,
  parameter int unsigned LINE_WIDTH = LINE_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  source_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  token_code_o,
  output logic [15:0] line_number_o,
  output logic [15:0] start_offset_o,
  output logic [15:0] token_length_o,
  output logic        last_of_run_o
);

  logic       in_v_q, room, fire;
  logic [7:0] in_b_q;
  logic [1:0] push_n;
  token_t     ent0, ent1, head;

  assign fire       = in_v_q && room;
  assign in_ready_o = !in_v_q || room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_b_q <= source_byte_i;
  end

  clex_scan #(.POS_WIDTH(POS_WIDTH), .LINE_WIDTH(LINE_WIDTH)) u_scan (
    .clk_i, .rst_ni, .fire_i(fire), .byte_i(in_b_q),
    .push_n_o(push_n), .ent0_o(ent0), .ent1_o(ent1)
  );

  clex_fifo u_fifo (
    .clk_i, .rst_ni, .push_n_i(push_n), .ent0_i(ent0), .ent1_i(ent1),
    .room_o(room), .valid_o(out_valid_o), .ready_i(out_ready_i), .data_o(head)
  );

  assign token_code_o   = head.code;
  assign line_number_o  = head.line;
  assign start_offset_o = head.start;
  assign token_length_o = head.len;
  assign last_of_run_o  = head.last;

endmodule

[src/clex_checker.sv]
// Port-level checks on the lexer's result channel, bound to the top level.
// Depends on clex_pkg and c_subset_lexer_dfa.
module clex_checker import clex_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [5:0]  token_code_o,
  input logic [15:0] line_number_o,
  input logic [15:0] token_length_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(token_code_o))
    else $error("result changed while stalled");

  a_end_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_code_o == TK_END |-> token_length_o == 16'd0)
    else $error("END with nonzero length");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && token_code_o == TK_END |=> !out_valid_o)
    else $error("result after END");

  a_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> line_number_o != 16'd0)
    else $error("line number zero");

endmodule

bind c_subset_lexer_dfa clex_checker u_clex_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .token_code_o, .line_number_o,
  .token_length_o
);
